FILE: hdl/cls_pkg.sv
package cls_pkg;

   localparam int DET_BITS = 64;
   localparam int SOL_BITS = 48;
   localparam int IDX_BITS = 2;
   localparam int CSR_DATA_BITS = 32;
   localparam int CSR_ADDR_BITS = 3;
   localparam int ORDER_BITS = 3;
   localparam logic [ORDER_BITS-1:0] ORDER_RESET = 3'd4;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_INIT,
      ST_SCAN,
      ST_READ,
      ST_MUL,
      ST_ACC,
      ST_STORE,
      ST_DET,
      ST_DIV,
      ST_EMIT
   } cls_state_type;

endpackage

FILE: hdl/cramer_linear_system_solver.sv
// Cramer's-rule solver for an n by n system (n = order, 1..MAX_ORDER; 0 acts as 1, larger
// values as MAX_ORDER). Coefficients arrive one word per cycle, row by row, right-hand side
// last in each row; writing order restarts the load. After the last word req_stall stays
// high while the block solves: every determinant is built by cofactor expansion over column
// subsets, one 64-bit multiply-accumulate term at a time via the scan, read, multiply and
// accumulate states, skipped subsets and columns passing through scan and each minor stored
// by the store state, on a single shared multiplier and minor store. The main determinant is
// done first; if zero, one word flagged no_solution and last comes out. Otherwise each unknown
// takes its determinant and 64+FRAC_BITS quotient bits from the shared one-bit-per-cycle divider,
// then one result word (Q.FRAC_BITS, truncated toward zero, clamped to 48 bits with saturated set).
module cramer_linear_system_solver #(
   parameter int MAX_ORDER = 4,
   parameter int COEF_BITS = 12,
   parameter int FRAC_BITS = 16
) (
   input  logic clock,
   input  logic reset,
   input  logic req_valid,
   output logic req_stall,
   input  logic signed [COEF_BITS-1:0] req_coefficient,
   output logic rsp_valid,
   input  logic rsp_stall,
   output logic [cls_pkg::IDX_BITS-1:0] rsp_unknown_index,
   output logic signed [cls_pkg::SOL_BITS-1:0] rsp_solution,
   output logic rsp_no_solution,
   output logic rsp_saturated,
   output logic rsp_last,
   input  logic psel,
   input  logic penable,
   input  logic pwrite,
   input  logic [cls_pkg::CSR_ADDR_BITS-1:0] paddr,
   input  logic [cls_pkg::CSR_DATA_BITS-1:0] pwdata,
   output logic [cls_pkg::CSR_DATA_BITS-1:0] prdata,
   output logic pready
);
   import cls_pkg::*;

   localparam int DEPTH = MAX_ORDER * (MAX_ORDER + 1);
   localparam int SW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int LW = $clog2(DEPTH + 1);
   localparam int NW = $clog2(MAX_ORDER + 1);
   localparam int CW = (MAX_ORDER > 1) ? $clog2(MAX_ORDER) : 1;
   localparam int MW = MAX_ORDER;
   localparam int QW = DET_BITS + FRAC_BITS;
   localparam int KW = $clog2(QW + 1);
   localparam int PW = DET_BITS + COEF_BITS;

   cls_state_type state_ff, state_in;
   logic [ORDER_BITS-1:0] order_ff, order_in;
   logic [LW-1:0] load_ff, load_in;
   logic [NW-1:0] sel_ff, sel_in, row_ff, row_in;
   logic [MW-1:0] mask_ff, mask_in;
   logic [CW-1:0] col_ff, col_in;
   logic [DET_BITS-1:0] acc_ff, acc_in, prod_ff, den_ff, den_in, rem_ff, rem_in;
   logic [DET_BITS-1:0] dp_rd_ff;
   logic signed [COEF_BITS-1:0] coef_rd_ff;
   logic d0_neg_ff, d0_neg_in, neg_ff, neg_in, nosol_ff, nosol_in;
   logic [QW-1:0] dvd_ff, dvd_in;
   logic [KW-1:0] cnt_ff, cnt_in;

   logic rsp_valid_ff, rsp_valid_in;
   logic [IDX_BITS-1:0] rsp_idx_ff, rsp_idx_in;
   logic [SOL_BITS-1:0] rsp_sol_ff, rsp_sol_in;
   logic rsp_nosol_ff, rsp_nosol_in, rsp_sat_ff, rsp_sat_in, rsp_last_ff, rsp_last_in;

   logic [COEF_BITS-1:0] store [DEPTH];
   logic [DET_BITS-1:0] dp_mem [2**MW];

   logic [NW-1:0] n_eff;
   logic [LW-1:0] total, load_idx, rd_addr;
   logic [MW-1:0] full, dp_rd_addr, dp_wr_addr;
   logic [DET_BITS-1:0] dp_wr_data;
   logic dp_we, st_we, rd_en, csr_we, qual, sign_odd, col_last, out_free, ge;
   logic signed [PW-1:0] prod_full;
   logic [DET_BITS-1:0] rem_sh;
   logic [SOL_BITS-1:0] lim, mval;
   logic sat;

   // effective order
   always_comb begin
      if (order_ff == '0) begin
         n_eff = NW'(1);
      end else if (order_ff > ORDER_BITS'(MAX_ORDER)) begin
         n_eff = NW'(MAX_ORDER);
      end else begin
         n_eff = NW'(order_ff);
      end
   end

   assign total = LW'(n_eff) * (LW'(n_eff) + LW'(1));
   assign load_idx = (load_ff >= total) ? '0 : load_ff;
   assign full = (MW'(1) << n_eff) - MW'(1);
   assign qual = ($countones(mask_ff) == int'(n_eff - row_ff));
   assign col_last = (int'(col_ff) == int'(n_eff) - 1);
   assign dp_rd_addr = mask_ff & ~(MW'(1) << col_ff);
   assign out_free = !rsp_valid_ff || !rsp_stall;
   assign csr_we = psel && penable && pwrite && (paddr[2] == 1'b0);

   // store address: replaced column reads the right-hand side
   always_comb begin
      logic [LW-1:0] colm;
      if ((sel_ff != '0) && (NW'(col_ff) == sel_ff - NW'(1))) begin
         colm = LW'(n_eff);
      end else begin
         colm = LW'(col_ff);
      end
      rd_addr = LW'(row_ff) * (LW'(n_eff) + LW'(1)) + colm;
   end

   // cofactor sign: parity of chosen columns left of col
   always_comb begin
      sign_odd = 1'b0;
      for (int i = 0; i < MW; i++) begin
         if ((i < int'(col_ff)) && mask_ff[i]) begin
            sign_odd = ~sign_odd;
         end
      end
   end

   assign prod_full = $signed(dp_rd_ff) * $signed(coef_rd_ff);
   assign rem_sh = {rem_ff[DET_BITS-2:0], dvd_ff[QW-1]};
   assign ge = (rem_sh >= den_ff);

   assign lim = neg_ff ? {1'b1, {(SOL_BITS-1){1'b0}}} : {1'b0, {(SOL_BITS-1){1'b1}}};
   assign sat = (dvd_ff > QW'(lim));
   assign mval = sat ? lim : dvd_ff[SOL_BITS-1:0];

   always_comb begin
      state_in = state_ff;
      order_in = order_ff;
      load_in = load_ff;
      sel_in = sel_ff;
      row_in = row_ff;
      mask_in = mask_ff;
      col_in = col_ff;
      acc_in = acc_ff;
      den_in = den_ff;
      rem_in = rem_ff;
      d0_neg_in = d0_neg_ff;
      neg_in = neg_ff;
      nosol_in = nosol_ff;
      dvd_in = dvd_ff;
      cnt_in = cnt_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_idx_in = rsp_idx_ff;
      rsp_sol_in = rsp_sol_ff;
      rsp_nosol_in = rsp_nosol_ff;
      rsp_sat_in = rsp_sat_ff;
      rsp_last_in = rsp_last_ff;
      dp_we = 1'b0;
      dp_wr_addr = mask_ff;
      dp_wr_data = acc_ff;
      st_we = 1'b0;
      rd_en = 1'b0;

      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               st_we = 1'b1;
               if (load_idx + LW'(1) == total) begin
                  load_in = '0;
                  sel_in = '0;
                  state_in = ST_INIT;
               end else begin
                  load_in = load_idx + LW'(1);
               end
            end
         end
         ST_INIT: begin
            dp_we = 1'b1;
            dp_wr_addr = '0;
            dp_wr_data = DET_BITS'(1);
            row_in = n_eff - NW'(1);
            mask_in = MW'(1);
            col_in = '0;
            acc_in = '0;
            state_in = ST_SCAN;
         end
         ST_SCAN: begin
            if (!qual) begin
               col_in = '0;
               if (mask_ff == full) begin
                  row_in = row_ff - NW'(1);
                  mask_in = MW'(1);
               end else begin
                  mask_in = mask_ff + MW'(1);
               end
            end else if (mask_ff[col_ff]) begin
               state_in = ST_READ;
            end else if (col_last) begin
               state_in = ST_STORE;
            end else begin
               col_in = col_ff + CW'(1);
            end
         end
         ST_READ: begin
            rd_en = 1'b1;
            state_in = ST_MUL;
         end
         ST_MUL: begin
            state_in = ST_ACC;
         end
         ST_ACC: begin
            acc_in = sign_odd ? acc_ff - prod_ff : acc_ff + prod_ff;
            if (col_last) begin
               state_in = ST_STORE;
            end else begin
               col_in = col_ff + CW'(1);
               state_in = ST_SCAN;
            end
         end
         ST_STORE: begin
            dp_we = 1'b1;
            col_in = '0;
            state_in = ST_SCAN;
            if (mask_ff == full) begin
               if (row_ff == '0) begin
                  state_in = ST_DET;
               end else begin
                  row_in = row_ff - NW'(1);
                  mask_in = MW'(1);
                  acc_in = '0;
               end
            end else begin
               mask_in = mask_ff + MW'(1);
               acc_in = '0;
            end
         end
         ST_DET: begin
            if (sel_ff == '0) begin
               if (acc_ff == '0) begin
                  nosol_in = 1'b1;
                  state_in = ST_EMIT;
               end else begin
                  den_in = acc_ff[DET_BITS-1] ? '0 - acc_ff : acc_ff;
                  d0_neg_in = acc_ff[DET_BITS-1];
                  sel_in = NW'(1);
                  state_in = ST_INIT;
               end
            end else begin
               neg_in = acc_ff[DET_BITS-1] ^ d0_neg_ff;
               dvd_in = QW'(acc_ff[DET_BITS-1] ? '0 - acc_ff : acc_ff) << FRAC_BITS;
               rem_in = '0;
               cnt_in = KW'(QW);
               state_in = ST_DIV;
            end
         end
         ST_DIV: begin
            dvd_in = {dvd_ff[QW-2:0], ge};
            rem_in = ge ? rem_sh - den_ff : rem_sh;
            cnt_in = cnt_ff - KW'(1);
            if (cnt_ff == KW'(1)) begin
               state_in = ST_EMIT;
            end
         end
         ST_EMIT: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               if (nosol_ff) begin
                  rsp_idx_in = '0;
                  rsp_sol_in = '0;
                  rsp_nosol_in = 1'b1;
                  rsp_sat_in = 1'b0;
                  rsp_last_in = 1'b1;
                  nosol_in = 1'b0;
                  state_in = ST_IDLE;
               end else begin
                  rsp_idx_in = IDX_BITS'(sel_ff - NW'(1));
                  rsp_sol_in = neg_ff ? SOL_BITS'(0) - mval : mval;
                  rsp_nosol_in = 1'b0;
                  rsp_sat_in = sat;
                  rsp_last_in = (sel_ff == n_eff);
                  if (sel_ff == n_eff) begin
                     state_in = ST_IDLE;
                  end else begin
                     sel_in = sel_ff + NW'(1);
                     state_in = ST_INIT;
                  end
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      if (csr_we) begin
         order_in = pwdata[ORDER_BITS-1:0];
         load_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         order_ff <= ORDER_RESET;
         load_ff <= '0;
         nosol_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         order_ff <= order_in;
         load_ff <= load_in;
         nosol_ff <= nosol_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      sel_ff <= sel_in;
      row_ff <= row_in;
      mask_ff <= mask_in;
      col_ff <= col_in;
      acc_ff <= acc_in;
      prod_ff <= prod_full[DET_BITS-1:0];
      den_ff <= den_in;
      rem_ff <= rem_in;
      d0_neg_ff <= d0_neg_in;
      neg_ff <= neg_in;
      dvd_ff <= dvd_in;
      cnt_ff <= cnt_in;
      rsp_idx_ff <= rsp_idx_in;
      rsp_sol_ff <= rsp_sol_in;
      rsp_nosol_ff <= rsp_nosol_in;
      rsp_sat_ff <= rsp_sat_in;
      rsp_last_ff <= rsp_last_in;
   end

   // coefficient store and minor store, registered reads
   always_ff @(posedge clock) begin
      if (st_we) begin
         store[load_idx[SW-1:0]] <= req_coefficient;
      end
      if (rd_en) begin
         coef_rd_ff <= store[rd_addr[SW-1:0]];
      end
   end

   always_ff @(posedge clock) begin
      if (dp_we) begin
         dp_mem[dp_wr_addr] <= dp_wr_data;
      end
      if (rd_en) begin
         dp_rd_ff <= dp_mem[dp_rd_addr];
      end
   end

   assign req_stall = (state_ff != ST_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_unknown_index = rsp_idx_ff;
   assign rsp_solution = rsp_sol_ff;
   assign rsp_no_solution = rsp_nosol_ff;
   assign rsp_saturated = rsp_sat_ff;
   assign rsp_last = rsp_last_ff;
   assign prdata = CSR_DATA_BITS'(order_ff);
   assign pready = 1'b1;

`ifndef SYNTHESIS
   a_nosol_word: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_no_solution |-> rsp_last && (rsp_solution == '0) && !rsp_saturated)
      else $error("no_solution word malformed");

   a_div_den: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_DIV |-> den_ff != '0)
      else $error("divide by zero determinant");

   a_emit_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> state_ff == $past(state_ff) || $past(state_ff) != ST_EMIT)
      else $error("emit left while output blocked");
`endif

endmodule
